>>> src/bitmap_page_allocator_unit_defines.svh
// Assertion macros for the bitmap page allocator.
// Included by the top level only; depends on nothing else.
`ifndef BITMAP_PAGE_ALLOCATOR_UNIT_DEFINES_SVH
`define BITMAP_PAGE_ALLOCATOR_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BPA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bitmap page allocator: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define BPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bitmap page allocator: next-cycle check failed");

`endif

>>> src/bpa_pkg.sv
// Shared types and constants of the bitmap page allocator.
// Used by the top level of the block; depends on nothing.
package bpa_pkg;

	localparam int MAP_WORDS_DEF  = 128;
	localparam int WORD_BITS_DEF  = 32;
	localparam int PAGE_SHIFT_DEF = 12;

	localparam int REQ_W        = 2;
	localparam int ADDR_W       = 24;
	localparam int STATUS_W     = 2;
	localparam int FREE_BYTES_W = 25;
	localparam int MEM_BYTES_W  = 25;

	localparam logic [MEM_BYTES_W-1:0] MEM_BYTES_RESET = 25'd16777216;

	typedef enum logic [REQ_W-1:0] {
		REQ_ALLOC = 2'd0,
		REQ_FREE  = 2'd1,
		REQ_INIT  = 2'd2,
		REQ_NOP   = 2'd3
	} req_t;

	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_OOM   = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_AREAD,
		ST_ACHECK,
		ST_FCHK,
		ST_FREAD,
		ST_FWRITE,
		ST_ISAT,
		ST_IFILL,
		ST_DONE
	} st_t;

endpackage

>>> src/bpa_map_ram.sv
// Used-map storage: one write port and one registered read port.
// Depends on nothing.
module bpa_map_ram #(
	parameter int DEPTH = 128,
	parameter int WIDTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> src/bpa_sub_unit.sv
// Shared subtract and compare unit used by the free and init steps of the sequencer.
// Depends on nothing.
module bpa_sub_unit #(
	parameter int W = 16
) (
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	output logic [W-1:0] diff,
	output logic         ge
);

	logic [W:0] full_diff;

	assign full_diff = {1'b0, a} - {1'b0, b};
	assign diff      = full_diff[W-1:0];
	assign ge        = ~full_diff[W];

endmodule

>>> src/bitmap_page_allocator_unit.sv
// Top level of the bitmap first-fit page allocator: sequencer and datapath.
// Depends on bpa_pkg, bpa_map_ram, bpa_sub_unit and the assertion macro header.
//
// Channel  Direction  Beat carries
// s_axis   in         tuser req_type, tdata page_addr
// m_axis   out        tuser status, tdata alloc_addr then free_bytes
// cfg      in         data memory_bytes
//
// After reset a clearing pass writes every map word as used; it takes no s_axis beats.
// Allocate: straight to the result when no page is free, else a read and a check per word,
// from the hint word on, until a word with a clear bit has its lowest clear bit set.
// Free: a range check, a map read and a write (range check alone beyond capacity); the word
// index is a shift of the page. Init: a saturation step, one map word written per cycle.
// A result waits in the output register; the sequencer holds in its last step while it is full.
`include "bitmap_page_allocator_unit_defines.svh"

module bitmap_page_allocator_unit #(
	parameter int MAP_WORDS  = bpa_pkg::MAP_WORDS_DEF,
	parameter int WORD_BITS  = bpa_pkg::WORD_BITS_DEF,
	parameter int PAGE_SHIFT = bpa_pkg::PAGE_SHIFT_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// page_addr [23:0]
	input  logic [bpa_pkg::ADDR_W-1:0]       s_axis_tdata,
	// req_type [1:0]
	input  logic [bpa_pkg::REQ_W-1:0]        s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// alloc_addr [23:0], free_bytes [48:24], zeros [55:49]
	output logic [55:0]                      m_axis_tdata,
	// status [1:0]
	output logic [bpa_pkg::STATUS_W-1:0]     m_axis_tuser,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [bpa_pkg::MEM_BYTES_W-1:0]  cfg_data
);

	localparam int CAP_PAGES = MAP_WORDS * WORD_BITS;
	localparam int CNT_W     = $clog2(CAP_PAGES + 1);
	localparam int MS_W      = bpa_pkg::MEM_BYTES_W - PAGE_SHIFT;
	localparam int PG_W      = bpa_pkg::ADDR_W - PAGE_SHIFT;
	localparam int UW        = (CNT_W > MS_W) ? CNT_W : MS_W;
	localparam int WIDX_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int BIDX_W    = $clog2(WORD_BITS);
	localparam int OUT_PAD   = 56 - bpa_pkg::ADDR_W - bpa_pkg::FREE_BYTES_W;
	localparam logic [WORD_BITS-1:0] FULL_WORD = {WORD_BITS{1'b1}};

	bpa_pkg::st_t state_q, state_d;

	logic [bpa_pkg::MEM_BYTES_W-1:0] mem_bytes_q;
	logic [CNT_W-1:0]                free_cnt_q;
	logic [WIDX_W-1:0]               hint_q;
	logic [UW-1:0]                   hint_base_q;
	logic [WIDX_W-1:0]               word_q;
	logic                            out_valid_q;

	logic [PG_W-1:0]                 page_q;
	logic [UW-1:0]                   rem_q;
	logic [WIDX_W-1:0]               quo_q;
	logic [UW-1:0]                   pages_q;
	logic [UW-1:0]                   scan_base_q;
	logic [bpa_pkg::STATUS_W-1:0]    res_status_q;
	logic [bpa_pkg::ADDR_W-1:0]      res_addr_q;
	logic [bpa_pkg::STATUS_W-1:0]    out_status_q;
	logic [bpa_pkg::ADDR_W-1:0]      out_addr_q;
	logic [bpa_pkg::FREE_BYTES_W-1:0] out_bytes_q;

	logic                            ram_we;
	logic [WIDX_W-1:0]               ram_waddr;
	logic [WORD_BITS-1:0]            ram_wdata;
	logic [WIDX_W-1:0]               ram_raddr;
	logic [WORD_BITS-1:0]            ram_rdata;

	logic [UW-1:0]                   u_a, u_b, u_diff;
	logic                            u_ge;

	logic                            in_acc;
	logic                            out_load;
	logic                            word_full;
	logic [BIDX_W-1:0]               zero_idx;
	logic [BIDX_W-1:0]               rem_idx;
	logic                            rem_bit_set;
	logic [WORD_BITS-1:0]            fill_word;
	logic [UW-1:0]                   alloc_page;
	logic                            last_word;

	bpa_map_ram #(
		.DEPTH(MAP_WORDS),
		.WIDTH(WORD_BITS)
	) u_map (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	bpa_sub_unit #(
		.W(UW)
	) u_sub (
		.a   (u_a),
		.b   (u_b),
		.diff(u_diff),
		.ge  (u_ge)
	);

	assign s_axis_tready = (state_q == bpa_pkg::ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;
	assign out_load      = (state_q == bpa_pkg::ST_DONE) && (!out_valid_q || m_axis_tready);
	assign last_word     = (word_q == WIDX_W'(MAP_WORDS - 1));

	assign word_full   = (ram_rdata == FULL_WORD);
	assign rem_idx     = rem_q[BIDX_W-1:0];
	assign rem_bit_set = ram_rdata[rem_idx];
	assign alloc_page  = scan_base_q + UW'(zero_idx);

	always_comb begin
		zero_idx = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (!ram_rdata[i]) begin
				zero_idx = BIDX_W'(i);
			end
		end
	end

	always_comb begin
		if (!u_ge) begin
			fill_word = FULL_WORD;
		end else if (u_diff >= UW'(WORD_BITS)) begin
			fill_word = '0;
		end else begin
			fill_word = FULL_WORD << u_diff[BIDX_W-1:0];
		end
	end

	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = word_q;
		ram_wdata = FULL_WORD;
		ram_raddr = word_q;
		u_a       = '0;
		u_b       = '0;
		unique case (state_q)
			bpa_pkg::ST_CLEAR: begin
				ram_we = 1'b1;
				if (last_word) begin
					state_d = bpa_pkg::ST_IDLE;
				end
			end
			bpa_pkg::ST_IDLE: begin
				if (in_acc) begin
					unique case (bpa_pkg::req_t'(s_axis_tuser))
						bpa_pkg::REQ_ALLOC: begin
							state_d = (free_cnt_q == '0) ? bpa_pkg::ST_DONE : bpa_pkg::ST_AREAD;
						end
						bpa_pkg::REQ_FREE: state_d = bpa_pkg::ST_FCHK;
						bpa_pkg::REQ_INIT: state_d = bpa_pkg::ST_ISAT;
						bpa_pkg::REQ_NOP:  state_d = bpa_pkg::ST_DONE;
					endcase
				end
			end
			bpa_pkg::ST_AREAD: begin
				state_d = bpa_pkg::ST_ACHECK;
			end
			bpa_pkg::ST_ACHECK: begin
				if (word_full) begin
					state_d = bpa_pkg::ST_AREAD;
				end else begin
					ram_we    = 1'b1;
					ram_wdata = ram_rdata | (WORD_BITS'(1) << zero_idx);
					state_d   = bpa_pkg::ST_DONE;
				end
			end
			bpa_pkg::ST_FCHK: begin
				u_a     = UW'(page_q);
				u_b     = UW'(CAP_PAGES);
				state_d = u_ge ? bpa_pkg::ST_DONE : bpa_pkg::ST_FREAD;
			end
			bpa_pkg::ST_FREAD: begin
				ram_raddr = quo_q;
				u_a       = UW'(page_q);
				u_b       = rem_q;
				state_d   = bpa_pkg::ST_FWRITE;
			end
			bpa_pkg::ST_FWRITE: begin
				ram_waddr = quo_q;
				ram_we    = rem_bit_set;
				ram_wdata = ram_rdata & ~(WORD_BITS'(1) << rem_idx);
				state_d   = bpa_pkg::ST_DONE;
			end
			bpa_pkg::ST_ISAT: begin
				u_a     = UW'(mem_bytes_q >> PAGE_SHIFT);
				u_b     = UW'(CAP_PAGES);
				state_d = bpa_pkg::ST_IFILL;
			end
			bpa_pkg::ST_IFILL: begin
				u_a       = pages_q;
				u_b       = scan_base_q;
				ram_we    = 1'b1;
				ram_wdata = fill_word;
				if (last_word) begin
					state_d = bpa_pkg::ST_DONE;
				end
			end
			bpa_pkg::ST_DONE: begin
				if (out_load) begin
					state_d = bpa_pkg::ST_IDLE;
				end
			end
			default: state_d = bpa_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bpa_pkg::ST_CLEAR;
			mem_bytes_q <= bpa_pkg::MEM_BYTES_RESET;
			free_cnt_q  <= '0;
			hint_q      <= '0;
			hint_base_q <= '0;
			word_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				mem_bytes_q <= cfg_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				bpa_pkg::ST_CLEAR: begin
					word_q <= last_word ? '0 : word_q + 1'b1;
				end
				bpa_pkg::ST_IDLE: begin
					word_q <= hint_q;
				end
				bpa_pkg::ST_ACHECK: begin
					if (word_full) begin
						word_q <= word_q + 1'b1;
					end else begin
						free_cnt_q  <= free_cnt_q - 1'b1;
						hint_q      <= word_q;
						hint_base_q <= scan_base_q;
					end
				end
				bpa_pkg::ST_FWRITE: begin
					if (rem_bit_set) begin
						free_cnt_q <= free_cnt_q + 1'b1;
						if (quo_q < hint_q) begin
							hint_q      <= quo_q;
							hint_base_q <= scan_base_q;
						end
					end
				end
				bpa_pkg::ST_ISAT: begin
					word_q <= '0;
				end
				bpa_pkg::ST_IFILL: begin
					word_q <= word_q + 1'b1;
					if (last_word) begin
						free_cnt_q  <= CNT_W'(pages_q);
						hint_q      <= '0;
						hint_base_q <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			bpa_pkg::ST_IDLE: begin
				page_q       <= s_axis_tdata[bpa_pkg::ADDR_W-1:PAGE_SHIFT];
				rem_q        <= UW'(s_axis_tdata[PAGE_SHIFT +: BIDX_W]);
				quo_q        <= WIDX_W'(s_axis_tdata[bpa_pkg::ADDR_W-1:PAGE_SHIFT] >> BIDX_W);
				scan_base_q  <= hint_base_q;
				res_addr_q   <= '0;
				res_status_q <= (bpa_pkg::req_t'(s_axis_tuser) == bpa_pkg::REQ_ALLOC
					&& free_cnt_q == '0) ? bpa_pkg::STATUS_OOM : bpa_pkg::STATUS_OK;
			end
			bpa_pkg::ST_ACHECK: begin
				if (word_full) begin
					scan_base_q <= scan_base_q + UW'(WORD_BITS);
				end else begin
					res_addr_q <= bpa_pkg::ADDR_W'(alloc_page) << PAGE_SHIFT;
				end
			end
			bpa_pkg::ST_FCHK: begin
				if (u_ge) begin
					res_status_q <= bpa_pkg::STATUS_RANGE;
				end
			end
			bpa_pkg::ST_FREAD: begin
				scan_base_q <= u_diff;
			end
			bpa_pkg::ST_ISAT: begin
				pages_q     <= u_ge ? UW'(CAP_PAGES) : u_a;
				scan_base_q <= '0;
			end
			bpa_pkg::ST_IFILL: begin
				scan_base_q <= scan_base_q + UW'(WORD_BITS);
			end
			default: begin
			end
		endcase
		if (out_load) begin
			out_status_q <= res_status_q;
			out_addr_q   <= res_addr_q;
			out_bytes_q  <= bpa_pkg::FREE_BYTES_W'(free_cnt_q) << PAGE_SHIFT;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_status_q;
	assign m_axis_tdata  = {{OUT_PAD{1'b0}}, out_bytes_q, out_addr_q};

	`BPA_ASSERT_NOW(a_count_within_capacity, clk, arst_n, 1'b1, free_cnt_q <= CNT_W'(CAP_PAGES))
	`BPA_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_acc, state_q != bpa_pkg::ST_IDLE)
	`BPA_ASSERT_NOW(a_oom_means_empty, clk, arst_n, m_axis_tvalid && m_axis_tuser == bpa_pkg::STATUS_OOM, m_axis_tdata[48:0] == '0)
	`BPA_ASSERT_NOW(a_addr_only_when_ok, clk, arst_n, m_axis_tvalid && m_axis_tuser != bpa_pkg::STATUS_OK, m_axis_tdata[23:0] == '0)

endmodule
